// ----- rtl/core/deq_pkg.sv -----
`default_nettype none

package deq_pkg;

    // field widths
    localparam int OPC_W  = 2;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;

    // operation codes
    localparam logic [OPC_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OPC_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OPC_W-1:0] OP_POP_REAR   = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic exec;   // word accepted: update pointers, access the store
        logic load;   // move the pending result into the output register
    } deq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/deq_if.sv -----
`default_nettype none

// operation channel
interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::OPC_W-1:0]           opcode;
    logic signed [deq_pkg::WORD_W-1:0]   push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// result channel
interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::STAT_W-1:0]          status;
    logic signed [deq_pkg::WORD_W-1:0]   popped_value;
    logic [deq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output status, output popped_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/deq_ctrl.sv -----
`default_nettype none

module deq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output deq_pkg::deq_cmd_t      cmd
);
    import deq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // handshake and commands
    assign req_ready = (state_reg == ST_IDLE);
    assign cmd.exec  = req_valid && req_ready;
    assign cmd.load  = (state_reg == ST_HOLD) && (!out_valid_reg || rsp_ready);
    assign rsp_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        priority if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("result load did not raise output valid");

    a_no_exec_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> !cmd.exec)
        else $error("word accepted while a result is pending");

    a_valid_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("output valid rose without a pending result");

    a_exec_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == ST_HOLD))
        else $error("accepted word did not enter hold");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/deq_dp.sv -----
`default_nettype none

module deq_dp #(
    parameter int CAPACITY = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire deq_pkg::deq_cmd_t                    cmd,
    input  wire logic [deq_pkg::OPC_W-1:0]            opcode,
    input  wire logic signed [deq_pkg::WORD_W-1:0]    push_value,
    output logic [deq_pkg::STAT_W-1:0]                status,
    output logic signed [deq_pkg::WORD_W-1:0]         popped_value,
    output logic [deq_pkg::OCC_W-1:0]                 occupancy
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S  = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_P = PTR_W'(CAPACITY - 1);

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [WORD_W-1:0] rd_data_reg;
    logic [STAT_W-1:0] stat_pend_reg;
    logic [STAT_W-1:0] stat_pend_next;
    logic              pop_ok_reg;
    logic              pop_ok_next;

    logic [STAT_W-1:0]        status_reg;
    logic signed [WORD_W-1:0] popped_reg;
    logic [OCC_W-1:0]         occ_reg;

    logic              full;
    logic              empty;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  head_dec;
    logic [SUM_W-1:0]  rear_sum;
    logic [SUM_W-1:0]  last_sum;
    logic [PTR_W-1:0]  rear_slot;
    logic [PTR_W-1:0]  last_slot;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;

    // pointer arithmetic, wrapped by a single compare
    assign full     = (count_reg == CAP_C);
    assign empty    = (count_reg == '0);
    assign head_inc = (head_reg == LAST_P) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? LAST_P : head_reg - PTR_W'(1);
    assign rear_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum = rear_sum - SUM_W'(1);
    assign rear_slot = (rear_sum >= CAP_S) ? PTR_W'(rear_sum - CAP_S) : PTR_W'(rear_sum);
    assign last_slot = (last_sum >= CAP_S) ? PTR_W'(last_sum - CAP_S) : PTR_W'(last_sum);

    // operation decode
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        stat_pend_next = STAT_DONE;
        pop_ok_next    = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = rear_slot;
        rd_addr        = head_reg;
        unique case (opcode)
            OP_PUSH_REAR:
            begin
                if (full)
                begin
                    stat_pend_next = STAT_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                wr_addr = head_dec;
                if (full)
                begin
                    stat_pend_next = STAT_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    stat_pend_next = STAT_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    head_next   = head_inc;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_POP_REAR:
            begin
                rd_addr = last_slot;
                if (empty)
                begin
                    stat_pend_next = STAT_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                stat_pend_next = STAT_DONE;
            end
        endcase
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // entry store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // pending result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stat_pend_reg <= stat_pend_next;
            pop_ok_reg    <= pop_ok_next;
        end
        if (cmd.load)
        begin
            status_reg <= stat_pend_reg;
            popped_reg <= pop_ok_reg ? $signed(rd_data_reg) : '0;
            occ_reg    <= OCC_W'(count_reg);
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign occupancy    = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_P)
        else $error("head pointer out of range");

    a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (stat_pend_next != STAT_DONE) |=>
            $stable(count_reg) && $stable(head_reg))
        else $error("refused operation changed the queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the count");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
`default_nettype none

// Double-ended queue of signed 32-bit words, CAPACITY entries, held in a
// circular store with a head pointer and an entry count. Each request word
// is one operation (push rear, push front, pop front, pop rear) and yields
// exactly one response word with status, popped value (zero unless a pop
// succeeded) and the occupancy after the operation. A push onto a full
// queue or a pop from an empty one changes nothing and reports full or
// empty. An operation is accepted while the block is idle, the store is
// accessed on that edge through its registered read port, and the result
// then waits in the hold stage until it is loaded into the response
// register; no new operation is accepted before that load. A response that is not taken
// keeps the following operation's result waiting in the hold stage, and no
// further operation is accepted until the response register is free.
// No clearing pass is needed after reset.
module double_ended_queue #(
    parameter int CAPACITY = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);
    import deq_pkg::*;

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    deq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (req.opcode),
        .push_value   (req.push_value),
        .status       (rsp.status),
        .popped_value (rsp.popped_value),
        .occupancy    (rsp.occupancy)
    );

endmodule

`default_nettype wire
